/* src/pgs_pkg.sv */
// Shared types, codes and default sizes for the pigeonhole sorter.
`default_nettype none

package pgs_pkg;

	localparam int DEF_VALUE_BITS = 10;
	localparam int DEF_HOLES      = 1024;
	localparam int DEF_MAX_ITEMS  = 4096;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_PULL   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic advance;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pull;
		logic stored_zero;
		logic hit;
		logic at_top;
		logic out_free;
		logic clear_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/pgs_if.sv */
// Handshake interfaces for the request and response channels of the sorter.
`default_nettype none

interface pgs_req_if #(
	parameter int VALUE_BITS = pgs_pkg::DEF_VALUE_BITS
);
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface pgs_rsp_if #(
	parameter int VALUE_BITS = pgs_pkg::DEF_VALUE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] sorted_value;
	logic                  last;
	logic [1:0]            status;

	modport source (output valid, output sorted_value, output last, output status,
		input ready);
	modport sink   (input valid, input sorted_value, input last, input status,
		output ready);
endinterface

`default_nettype wire

/* src/pigeonhole_sorter.sv */
// Top level of the pigeonhole sorter: controller and datapath.
//
// The req channel carries one transaction per operation: op selects insert
// (value goes into its hole) or pull (next smallest stored value). Every
// request produces exactly one transaction on the rsp channel with
// sorted_value, last and status (ok, empty on a pull with nothing stored,
// full when an insert is dropped for capacity or for a value beyond the holes).
//
// An insert is accepted in the idle state and committed to the output register
// from the execute state. A pull there also steps over each empty hole, reading
// the count memory one hole per cycle through its single read port while the
// output register is free. The block works on one request at a time and takes
// the next request once the current response is in the output register.
//
// After reset a clearing pass writes zero into all HOLES count entries, one per
// cycle; req.ready stays low until the pass is done.
//
// When the receiver stalls, the response waits in the output register. The
// next request is still accepted, but its hole scan and its response both wait
// until the output register is free again.
`default_nettype none

module pigeonhole_sorter #(
	parameter int VALUE_BITS = pgs_pkg::DEF_VALUE_BITS,
	parameter int HOLES      = pgs_pkg::DEF_HOLES,
	parameter int MAX_ITEMS  = pgs_pkg::DEF_MAX_ITEMS
) (
	input  logic            clk,
	input  logic            arst_n,
	pgs_req_if.sink         req,
	pgs_rsp_if.source       rsp
);
	import pgs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller owns the request handshake; the datapath owns the payload
	// and the response register.
	pgs_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pgs_datapath #(
		.VALUE_BITS (VALUE_BITS),
		.HOLES      (HOLES),
		.MAX_ITEMS  (MAX_ITEMS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.req_op           (req.op),
		.req_value        (req.value),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_sorted_value (rsp.sorted_value),
		.rsp_last         (rsp.last),
		.rsp_status       (rsp.status)
	);

endmodule

`default_nettype wire

/* src/pgs_controller.sv */
// Sequencer for the sorter: clearing pass, transaction intake and hole scan.
`default_nettype none

module pgs_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  pgs_pkg::dp_stat_t  stat,
	output pgs_pkg::dp_cmd_t   cmd
);
	import pgs_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       decide;

	// In the execute state the transaction is finished once the hole holds a count,
	// the scan reaches the top, or the operation needs no scan at all.
	assign decide = !stat.is_pull || stat.stored_zero || stat.hit || stat.at_top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free && decide) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.commit  = decide;
					cmd.advance = !decide;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/pgs_datapath.sv */
// Count memory, set bounds, scan pointer and response register of the sorter.
`default_nettype none

module pgs_datapath #(
	parameter int VALUE_BITS = pgs_pkg::DEF_VALUE_BITS,
	parameter int HOLES      = pgs_pkg::DEF_HOLES,
	parameter int MAX_ITEMS  = pgs_pkg::DEF_MAX_ITEMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgs_pkg::dp_cmd_t      cmd,
	output pgs_pkg::dp_stat_t     stat,
	input  logic                  req_op,
	input  logic [VALUE_BITS-1:0] req_value,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [VALUE_BITS-1:0] rsp_sorted_value,
	output logic                  rsp_last,
	output logic [1:0]            rsp_status
);
	import pgs_pkg::*;

	localparam int AW = (HOLES > 1) ? $clog2(HOLES) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [VALUE_BITS-1:0] VMASK = '1;

	logic [CW-1:0]         mem [HOLES];
	logic [CW-1:0]         rd_q;
	logic [VALUE_BITS-1:0] pos_q;
	op_t                   op_q;
	logic [VALUE_BITS-1:0] smallest_q;
	logic [VALUE_BITS-1:0] largest_q;
	logic [VALUE_BITS-1:0] scan_q;
	logic [CW-1:0]         stored_q;
	logic                  draining_q;
	logic [AW-1:0]         clr_q;
	logic                  rsp_valid_q;
	logic [VALUE_BITS-1:0] rsp_value_q;
	logic                  rsp_last_q;
	status_t               rsp_status_q;

	logic [VALUE_BITS-1:0] start_pos;
	logic [VALUE_BITS-1:0] next_pos;
	logic [VALUE_BITS-1:0] rd_pos;
	logic                  full;
	logic                  ins_ok;
	logic                  pull_ok;
	logic                  pull_last;

	assign start_pos = (op_t'(req_op) == OP_INSERT) ? req_value :
		(draining_q ? scan_q : smallest_q);
	assign next_pos  = VALUE_BITS'(pos_q + 1'b1);
	assign rd_pos    = cmd.accept ? start_pos : (cmd.advance ? next_pos : pos_q);

	// A value beyond the holes is dropped like an insert into a full store.
	assign full      = (stored_q >= CW'(MAX_ITEMS)) || (32'(pos_q) >= 32'(HOLES));
	assign ins_ok    = (op_q == OP_INSERT) && !full;
	assign pull_ok   = (op_q == OP_PULL) && (stored_q != '0) && (rd_q != '0);
	assign pull_last = (stored_q == CW'(1));

	assign stat.is_pull     = (op_q == OP_PULL);
	assign stat.stored_zero = (stored_q == '0);
	assign stat.hit         = (rd_q != '0);
	assign stat.at_top      = (pos_q >= largest_q);
	assign stat.out_free    = !rsp_valid_q || rsp_ready;
	assign stat.clear_last  = (clr_q == AW'(HOLES - 1));

	// Count memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= '0;
		end else if (cmd.commit && (ins_ok || pull_ok)) begin
			mem[AW'(pos_q)] <= ins_ok ? CW'(rd_q + 1'b1) : CW'(rd_q - 1'b1);
		end
		rd_q <= mem[AW'(rd_pos)];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op_t'(req_op);
		end
		if (cmd.accept || cmd.advance) begin
			pos_q <= rd_pos;
		end
		if (cmd.commit) begin
			rsp_value_q  <= pull_ok ? pos_q : '0;
			rsp_last_q   <= pull_ok && pull_last;
			if (op_q == OP_INSERT) begin
				rsp_status_q <= full ? STAT_FULL : STAT_OK;
			end else begin
				rsp_status_q <= pull_ok ? STAT_OK : STAT_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			stored_q    <= '0;
			smallest_q  <= VMASK;
			largest_q   <= '0;
			scan_q      <= '0;
			draining_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.commit && ins_ok) begin
				stored_q <= CW'(stored_q + 1'b1);
				if (pos_q < smallest_q) begin
					smallest_q <= pos_q;
				end
				if (pos_q > largest_q) begin
					largest_q <= pos_q;
				end
				if (draining_q && (pos_q < scan_q)) begin
					scan_q <= pos_q;
				end
			end else if (cmd.commit && pull_ok) begin
				stored_q <= CW'(stored_q - 1'b1);
				if (pull_last) begin
					smallest_q <= VMASK;
					largest_q  <= '0;
					scan_q     <= '0;
					draining_q <= 1'b0;
				end else begin
					draining_q <= 1'b1;
					scan_q     <= pos_q;
				end
			end
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_sorted_value = rsp_value_q;
	assign rsp_last         = rsp_last_q;
	assign rsp_status       = rsp_status_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("result committed while the response register is occupied");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed result not presented");

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(MAX_ITEMS))
		else $error("stored item count beyond capacity");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_q != '0) |-> (smallest_q <= largest_q))
		else $error("smallest seen above largest seen with items stored");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (stored_q != '0))
		else $error("hole scan advanced with nothing stored");

endmodule

`default_nettype wire
